// ----- rtl/arsc_pkg.sv -----
// ----------------------------------------------------------------------------
// Aging raster slot cache package
// Shared widths, codes and the interface structs between the core and the
// slot table.
// ----------------------------------------------------------------------------
package arsc_pkg;

  localparam int unsigned SLOTS      = 18;
  localparam int unsigned SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int unsigned MODE_W     = 1;
  localparam int unsigned RASTER_W   = 7;
  localparam int unsigned SPRITE_W   = 8;
  localparam int unsigned DESC_W     = 32;
  localparam int unsigned OFFSET_W   = 20;
  localparam int unsigned SIZE_LSB   = 20;
  localparam int unsigned AGE_W      = 2;
  localparam int unsigned ACTIVE_W   = 5;
  localparam int unsigned SBYTES_W   = 16;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SLOT_W     = 5;
  localparam int unsigned BUF_OFF_W  = 21;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned BYTES_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned IN_DATA_W  = RASTER_W + SPRITE_W + DESC_W;
  localparam int unsigned IN_TDATA_W = ((IN_DATA_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = SLOT_W + BUF_OFF_W + ADDR_W + BYTES_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

  localparam logic [AGE_W-1:0]    AGE_FRESH      = 2'd2;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET   = 5'd18;
  localparam logic [SBYTES_W-1:0] SBYTES_RESET   = 16'd4096;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 1'b0,
    MODE_TICK   = 1'b1
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_HIT  = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE     = 2'd0,
    CFG_SLOT_BYTES = 2'd1,
    CFG_ROM_BASE   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                tick;
    logic                lookup;
    logic [RASTER_W-1:0] raster;
    logic [SPRITE_W-1:0] sprite;
  } tbl_req_t;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_IDX_W-1:0] hit_slot;
    logic                  have_free;
    logic [SLOT_IDX_W-1:0] free_slot;
  } tbl_rsp_t;

endpackage

// ----- rtl/aging_raster_slot_cache_core.sv -----
// ----------------------------------------------------------------------------
// Aging raster slot cache core
// Fully associative slot cache keyed by raster index and sprite id, with
// per-slot aging and load requests on allocation.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries requests: tuser selects a lookup or an aging
// tick, tdata holds raster index, sprite id and descriptor word. Every
// lookup yields one result on the master stream, with the status in tuser
// and slot, buffer offset, load address and byte count in tdata. A tick
// yields no result. The configuration channel writes the active slot count,
// the per-slot byte size and the ROM base; write it only while idle.
// A request is registered on transfer, then compared against all slots and
// its result registered; the compare and pick over the tag table are
// combinational. One request per cycle is taken while no lookup waits on
// a stalled result. When the receiver stalls with a result pending,
// lookups wait in the input register while ticks still pass. Reset frees
// every slot and loads the default register values; the block is ready to
// take a request as soon as reset is released.
// ----------------------------------------------------------------------------
module aging_raster_slot_cache_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // raster_index [6:0], sprite_id [14:7], descriptor_word [46:15]
  input  logic [arsc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // mode [0]
  input  logic [arsc_pkg::MODE_W-1:0]         s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // slot [4:0], buffer_offset [25:5], load_address [57:26], load_bytes [73:58]
  output logic [arsc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // status [1:0]
  output logic [arsc_pkg::STATUS_W-1:0]       m_axis_tuser,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [arsc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [arsc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import arsc_pkg::*;

  logic [ACTIVE_W-1:0] active_q;
  logic [SBYTES_W-1:0] slot_bytes_q;
  logic [ADDR_W-1:0]   rom_base_q;

  logic                in_valid_q;
  mode_e               in_mode_q;
  logic [RASTER_W-1:0] in_raster_q;
  logic [SPRITE_W-1:0] in_sprite_q;
  logic [DESC_W-1:0]   in_desc_q;

  logic                 out_valid_q;
  status_e              out_status_q, out_status_d;
  logic [SLOT_W-1:0]    out_slot_q, out_slot_d;
  logic [BUF_OFF_W-1:0] out_buf_q, out_buf_d;
  logic [ADDR_W-1:0]    out_addr_q, out_addr_d;
  logic [BYTES_W-1:0]   out_bytes_q, out_bytes_d;

  logic     advance;
  logic     in_tick;
  tbl_req_t tbl_req;
  tbl_rsp_t tbl_rsp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= ACTIVE_RESET;
      slot_bytes_q <= SBYTES_RESET;
      rom_base_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ACTIVE:     active_q     <= cfg_data_i[ACTIVE_W-1:0];
        CFG_SLOT_BYTES: slot_bytes_q <= cfg_data_i[SBYTES_W-1:0];
        CFG_ROM_BASE:   rom_base_q   <= cfg_data_i[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tick       = (in_mode_q == MODE_TICK);
  assign advance       = in_valid_q && (in_tick || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode_q   <= mode_e'(s_axis_tuser);
      in_raster_q <= s_axis_tdata[RASTER_W-1:0];
      in_sprite_q <= s_axis_tdata[RASTER_W +: SPRITE_W];
      in_desc_q   <= s_axis_tdata[RASTER_W + SPRITE_W +: DESC_W];
    end
  end

  always_comb begin
    tbl_req.tick   = advance && in_tick;
    tbl_req.lookup = advance && !in_tick;
    tbl_req.raster = in_raster_q;
    tbl_req.sprite = in_sprite_q;
  end

  arsc_slot_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .active_i (active_q),
    .req_i    (tbl_req),
    .rsp_o    (tbl_rsp)
  );

  always_comb begin
    out_status_d = STAT_FULL;
    out_slot_d   = '0;
    out_addr_d   = '0;
    out_bytes_d  = '0;
    if (tbl_rsp.hit) begin
      out_status_d = STAT_HIT;
      out_slot_d   = SLOT_W'(tbl_rsp.hit_slot);
    end else if (tbl_rsp.have_free) begin
      out_status_d = STAT_MISS;
      out_slot_d   = SLOT_W'(tbl_rsp.free_slot);
      out_addr_d   = rom_base_q + ADDR_W'(in_desc_q[OFFSET_W-1:0]);
      out_bytes_d  = BYTES_W'({in_desc_q[DESC_W-1:SIZE_LSB], 4'b0000});
    end
    out_buf_d = BUF_OFF_W'(out_slot_d * slot_bytes_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tbl_req.lookup) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_req.lookup) begin
      out_status_q <= out_status_d;
      out_slot_q   <= out_slot_d;
      out_buf_q    <= out_buf_d;
      out_addr_q   <= out_addr_d;
      out_bytes_q  <= out_bytes_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_bytes_q, out_addr_q, out_buf_q, out_slot_q});

endmodule

// ----- rtl/arsc_slot_table.sv -----
// ----------------------------------------------------------------------------
// Aging raster slot cache tag table
// Holds tag and age per slot, compares all active slots in parallel, picks
// the first hit and the first free slot, and applies tick and lookup updates.
// ----------------------------------------------------------------------------
module arsc_slot_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [arsc_pkg::ACTIVE_W-1:0]   active_i,
  input  arsc_pkg::tbl_req_t              req_i,
  output arsc_pkg::tbl_rsp_t              rsp_o
);
  import arsc_pkg::*;

  logic [AGE_W-1:0]    age_q    [SLOTS];
  logic [RASTER_W-1:0] raster_q [SLOTS];
  logic [SPRITE_W-1:0] sprite_q [SLOTS];
  logic [SLOTS-1:0]    active;
  logic [SLOTS-1:0]    live;
  logic [SLOTS-1:0]    match;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      active[i] = 32'(active_i) > 32'(i);
      live[i]   = active[i] && (age_q[i] != '0);
      match[i]  = live[i] && (raster_q[i] == req_i.raster) && (sprite_q[i] == req_i.sprite);
    end
  end

  always_comb begin
    rsp_o = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        rsp_o.hit      = 1'b1;
        rsp_o.hit_slot = SLOT_IDX_W'(i);
      end
      if (active[i] && !live[i]) begin
        rsp_o.have_free = 1'b1;
        rsp_o.free_slot = SLOT_IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        age_q[i] <= '0;
      end
    end else if (req_i.tick) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (live[i]) begin
          age_q[i] <= age_q[i] - AGE_W'(1);
        end
      end
    end else if (req_i.lookup) begin
      if (rsp_o.hit) begin
        age_q[rsp_o.hit_slot] <= AGE_FRESH;
      end else if (rsp_o.have_free) begin
        age_q[rsp_o.free_slot] <= AGE_FRESH;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.lookup && !rsp_o.hit && rsp_o.have_free) begin
      raster_q[rsp_o.free_slot] <= req_i.raster;
      sprite_q[rsp_o.free_slot] <= req_i.sprite;
    end
  end

endmodule

// ----- sim/aging_raster_slot_cache_core_tb.sv -----
// ----------------------------------------------------------------------------
// Aging raster slot cache core testbench
// Drives lookups and aging ticks into the cache, with random gaps on the
// request stream and random stalls on the result stream. A directed table
// covers the field extremes, hit, miss, full, expiry and the active count
// corner cases. Random phases then reprogram the registers and send tags
// drawn from a small pool. Every result is checked against the value that
// the table gives, else against a cycle-free model running beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module aging_raster_slot_cache_core_tb;
  import arsc_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 160;
  localparam int unsigned MAX_GAP      = 12;
  localparam int unsigned POOL_MAX     = 32;

  typedef struct packed {
    status_e               status;
    logic [SLOT_W-1:0]     slot;
    logic [BUF_OFF_W-1:0]  buf_off;
    logic [ADDR_W-1:0]     load_addr;
    logic [BYTES_W-1:0]    load_bytes;
  } slot_result_t;

  typedef enum bit {
    ROW_ITEM,
    ROW_REG
  } row_kind_e;

  typedef struct {
    row_kind_e           kind;
    cfg_idx_e            reg_idx;
    logic [31:0]         reg_val;
    mode_e               mode;
    logic [RASTER_W-1:0] raster;
    logic [SPRITE_W-1:0] sprite;
    logic [DESC_W-1:0]   desc;
    bit                  typed;
    slot_result_t        want;
  } plan_row_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [IN_TDATA_W-1:0]     s_axis_tdata;
  logic [MODE_W-1:0]         s_axis_tuser;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [OUT_TDATA_W-1:0]    m_axis_tdata;
  logic [STATUS_W-1:0]       m_axis_tuser;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i;
  logic [CFG_DATA_W-1:0]     cfg_data_i;

  // Model of the slot table and the registers.
  logic [AGE_W-1:0]      slot_age    [SLOTS];
  logic [RASTER_W-1:0]   slot_raster [SLOTS];
  logic [SPRITE_W-1:0]   slot_sprite [SLOTS];
  logic [ACTIVE_W-1:0]   cfg_active;
  logic [SBYTES_W-1:0]   cfg_slot_bytes;
  logic [ADDR_W-1:0]     cfg_rom_base;

  slot_result_t pending_results[$];
  plan_row_t    plan[$];

  bit tx_calm;
  bit rx_calm;
  int unsigned n_lookups;
  int unsigned n_ticks;
  int unsigned n_reg_writes;
  int unsigned n_checked;
  int unsigned n_hits;
  int unsigned n_misses;
  int unsigned n_full;
  int unsigned n_errors;

  aging_raster_slot_cache_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("Timeout with %0d results still outstanding.", pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  function automatic void cache_reset();
    for (int i = 0; i < SLOTS; i++) begin
      slot_age[i]    = '0;
      slot_raster[i] = '0;
      slot_sprite[i] = '1;
    end
    cfg_active     = ACTIVE_RESET;
    cfg_slot_bytes = SBYTES_RESET;
    cfg_rom_base   = '0;
  endfunction

  function automatic slot_result_t slot_hit_result(status_e st, int unsigned idx);
    slot_result_t r;
    logic [31:0]  prod;
    r        = '0;
    prod     = 32'(idx) * 32'(cfg_slot_bytes);
    r.status = st;
    r.slot   = SLOT_W'(idx);
    r.buf_off = prod[BUF_OFF_W-1:0];
    return r;
  endfunction

  // Applies one request to the model; returns 1 when it yields a result.
  function automatic bit cache_access(mode_e m, logic [RASTER_W-1:0] ras,
                                      logic [SPRITE_W-1:0] spr, logic [DESC_W-1:0] desc,
                                      output slot_result_t r);
    int unsigned live;
    bit          found_free;
    int unsigned free_idx;
    live       = (32'(cfg_active) > SLOTS) ? SLOTS : 32'(cfg_active);
    found_free = 1'b0;
    free_idx   = 0;
    r          = '0;
    if (m == MODE_TICK) begin
      for (int i = 0; i < live; i++) begin
        if (slot_age[i] != '0) slot_age[i] = slot_age[i] - AGE_W'(1);
      end
      return 1'b0;
    end
    for (int i = 0; i < live; i++) begin
      if (slot_age[i] != '0) begin
        if (slot_raster[i] == ras && slot_sprite[i] == spr) begin
          slot_age[i] = AGE_FRESH;
          r = slot_hit_result(STAT_HIT, i);
          return 1'b1;
        end
      end else if (!found_free) begin
        found_free = 1'b1;
        free_idx   = i;
      end
    end
    if (!found_free) begin
      r.status = STAT_FULL;
      return 1'b1;
    end
    slot_raster[free_idx] = ras;
    slot_sprite[free_idx] = spr;
    slot_age[free_idx]    = AGE_FRESH;
    r = slot_hit_result(STAT_MISS, free_idx);
    r.load_addr  = cfg_rom_base + {12'd0, desc[OFFSET_W-1:0]};
    r.load_bytes = desc[31:16] & 16'hFFF0;
    return 1'b1;
  endfunction

  function automatic slot_result_t mk_result(status_e st, logic [SLOT_W-1:0] sl,
                                             logic [BUF_OFF_W-1:0] off,
                                             logic [ADDR_W-1:0] addr,
                                             logic [BYTES_W-1:0] nbytes);
    slot_result_t r;
    r.status     = st;
    r.slot       = sl;
    r.buf_off    = off;
    r.load_addr  = addr;
    r.load_bytes = nbytes;
    return r;
  endfunction

  function automatic void add_item(mode_e m, logic [RASTER_W-1:0] ras,
                                   logic [SPRITE_W-1:0] spr, logic [DESC_W-1:0] desc,
                                   bit typed = 1'b0, slot_result_t want = '0);
    plan_row_t row;
    row.kind    = ROW_ITEM;
    row.reg_idx = CFG_ACTIVE;
    row.reg_val = '0;
    row.mode    = m;
    row.raster  = ras;
    row.sprite  = spr;
    row.desc    = desc;
    row.typed   = typed;
    row.want    = want;
    plan.push_back(row);
  endfunction

  function automatic void add_reg(cfg_idx_e idx, logic [31:0] val);
    plan_row_t row;
    row.kind    = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    row.mode    = MODE_LOOKUP;
    row.raster  = '0;
    row.sprite  = '0;
    row.desc    = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    plan.push_back(row);
  endfunction

  // Called at the clock edge of the previous transfer, or while the stream is idle.
  task automatic send_request(mode_e m, logic [RASTER_W-1:0] ras, logic [SPRITE_W-1:0] spr,
                              logic [DESC_W-1:0] desc, bit typed, slot_result_t want);
    int unsigned  gap;
    slot_result_t r;
    bit           produced;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= m;
    s_axis_tdata  <= {{(IN_TDATA_W - IN_DATA_W){1'b0}}, desc, spr, ras};
    do @(posedge clk_i); while (!s_axis_tready);
    produced = cache_access(m, ras, spr, desc, r);
    if (produced) begin
      pending_results.push_back(typed ? want : r);
      n_lookups++;
    end else begin
      n_ticks++;
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_ACTIVE:     cfg_active     = val[ACTIVE_W-1:0];
      CFG_SLOT_BYTES: cfg_slot_bytes = val[SBYTES_W-1:0];
      CFG_ROM_BASE:   cfg_rom_base   = val;
      default: ;
    endcase
    n_reg_writes++;
  endtask

  initial begin
    slot_result_t got;
    slot_result_t want;
    int unsigned  stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.status     = status_e'(m_axis_tuser);
      got.slot       = m_axis_tdata[4:0];
      got.buf_off    = m_axis_tdata[25:5];
      got.load_addr  = m_axis_tdata[57:26];
      got.load_bytes = m_axis_tdata[73:58];
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("%0t: result with none expected: status %0d slot %0d", $realtime,
                   got.status, got.slot);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        case (want.status)
          STAT_HIT:  n_hits++;
          STAT_MISS: n_misses++;
          default:   n_full++;
        endcase
        if (got.status !== want.status || got.slot !== want.slot ||
            got.buf_off !== want.buf_off || got.load_addr !== want.load_addr ||
            got.load_bytes !== want.load_bytes) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("%0t: mismatch on result %0d", $realtime, n_checked);
            $display("  expected status %0d slot %0d offset %h addr %h bytes %h",
                     want.status, want.slot, want.buf_off, want.load_addr, want.load_bytes);
            $display("  actual   status %0d slot %0d offset %h addr %h bytes %h",
                     got.status, got.slot, got.buf_off, got.load_addr, got.load_bytes);
          end
        end
      end
    end
  end

  initial begin
    logic [RASTER_W-1:0] pool_raster [POOL_MAX];
    logic [SPRITE_W-1:0] pool_sprite [POOL_MAX];
    int unsigned         pool_size;
    int unsigned         tick_div;
    int unsigned         pick;
    logic [RASTER_W-1:0] ras;
    logic [SPRITE_W-1:0] spr;
    logic [31:0]         act_val;
    logic [31:0]         bytes_val;
    logic [31:0]         base_val;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_LOOKUP;
    m_axis_tready <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_ACTIVE;
    cfg_data_i    <= '0;
    tx_calm       = 1'b0;
    rx_calm       = 1'b0;
    cache_reset();

    add_item(MODE_LOOKUP, 7'd0, 8'd0, 32'h0000_0000, 1'b1,
             mk_result(STAT_MISS, 5'd0, 21'd0, 32'h0, 16'h0));
    add_item(MODE_LOOKUP, 7'd0, 8'd0, 32'h1234_5678, 1'b1,
             mk_result(STAT_HIT, 5'd0, 21'd0, 32'h0, 16'h0));
    add_item(MODE_LOOKUP, 7'd127, 8'd255, 32'hFFFF_FFFF, 1'b1,
             mk_result(STAT_MISS, 5'd1, 21'd4096, 32'h000F_FFFF, 16'hFFF0));
    // Free model slots hold the reset tag, which must not match at age zero.
    add_item(MODE_LOOKUP, 7'd0, 8'd255, 32'h8765_4321);
    add_item(MODE_TICK, 7'd127, 8'd255, 32'hFFFF_FFFF);
    add_item(MODE_TICK, 7'd0, 8'd0, 32'h0000_0000);
    add_item(MODE_LOOKUP, 7'd127, 8'd255, 32'h0010_0001);
    add_reg(CFG_ACTIVE, 32'd1);
    add_reg(CFG_ROM_BASE, 32'hFFFF_FFFF);
    add_reg(CFG_SLOT_BYTES, 32'h0000_FFFF);
    add_item(MODE_LOOKUP, 7'd5, 8'd6, 32'h000F_FFFF, 1'b1,
             mk_result(STAT_FULL, 5'd0, 21'd0, 32'h0, 16'h0));
    add_item(MODE_LOOKUP, 7'd127, 8'd255, 32'h0000_0000, 1'b1,
             mk_result(STAT_HIT, 5'd0, 21'd0, 32'h0, 16'h0));
    add_item(MODE_TICK, 7'd0, 8'd0, 32'h0);
    add_item(MODE_TICK, 7'd0, 8'd0, 32'h0);
    add_item(MODE_LOOKUP, 7'd1, 8'd2, 32'hABCD_E123);
    add_reg(CFG_ACTIVE, 32'd0);
    add_item(MODE_LOOKUP, 7'd1, 8'd2, 32'h0, 1'b1,
             mk_result(STAT_FULL, 5'd0, 21'd0, 32'h0, 16'h0));
    add_item(MODE_TICK, 7'd0, 8'd0, 32'h0);
    add_reg(CFG_ACTIVE, 32'd31);
    add_item(MODE_LOOKUP, 7'd1, 8'd2, 32'h0, 1'b1,
             mk_result(STAT_HIT, 5'd0, 21'd0, 32'h0, 16'h0));
    add_item(MODE_LOOKUP, 7'd3, 8'd4, 32'hFFFF_0000);
    add_reg(CFG_SLOT_BYTES, 32'd0);
    add_item(MODE_LOOKUP, 7'd9, 8'd9, 32'h5A5A_A5A5);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG)
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      else
        send_request(plan[i].mode, plan[i].raster, plan[i].sprite, plan[i].desc,
                     plan[i].typed, plan[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       act_val = 32'd18;
        1:       act_val = 32'd1;
        2:       act_val = 32'd31;
        3:       act_val = 32'd2;
        default: act_val = $urandom_range(1, 31);
      endcase
      case (p)
        0:       bytes_val = 32'd4096;
        1, 4:    bytes_val = 32'h0000_FFFF;
        2:       bytes_val = 32'd0;
        default: bytes_val = $urandom_range(0, 65535);
      endcase
      case (p)
        0, 2:    base_val = 32'h0;
        1:       base_val = 32'hFFFF_FFFF;
        default: base_val = $urandom();
      endcase
      write_reg(CFG_ACTIVE, act_val);
      write_reg(CFG_SLOT_BYTES, bytes_val);
      write_reg(CFG_ROM_BASE, base_val);

      tx_calm   = ($urandom_range(0, 3) == 0);
      rx_calm   = ($urandom_range(0, 3) == 0);
      pool_size = $urandom_range(2, POOL_MAX);
      tick_div  = $urandom_range(3, 10);
      for (int k = 0; k < POOL_MAX; k++) begin
        pool_raster[k] = RASTER_W'($urandom_range(0, 127));
        pool_sprite[k] = SPRITE_W'($urandom_range(0, 255));
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) begin
          tx_calm = ~tx_calm;
          rx_calm = ($urandom_range(0, 2) == 0);
        end
        pick = $urandom_range(0, pool_size - 1);
        ras  = pool_raster[pick];
        spr  = pool_sprite[pick];
        if ($urandom_range(0, 15) == 0) begin
          ras = RASTER_W'($urandom_range(0, 127));
          spr = SPRITE_W'($urandom_range(0, 255));
        end
        if ($urandom_range(1, tick_div) == 1)
          send_request(MODE_TICK, RASTER_W'($urandom_range(0, 127)),
                       SPRITE_W'($urandom_range(0, 255)), $urandom(), 1'b0, '0);
        else
          send_request(MODE_LOOKUP, ras, spr, $urandom(), 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES * 2) @(posedge clk_i);

    $display("Sent %0d lookups and %0d ticks over %0d register writes.",
             n_lookups, n_ticks, n_reg_writes);
    $display("Checked %0d results: %0d hits, %0d misses, %0d full; %0d errors.",
             n_checked, n_hits, n_misses, n_full, n_errors);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
